// ===== hw/rtl/i2cbs_pkg.sv =====
// Package with command codes and bus phase tables for the I2C master bit sequencer.
`default_nettype none

package i2cbs_pkg;

  // Command codes; the tick code doubles as the idle marker of the active command.
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_e;

  localparam logic [7:0] HalfPeriodReset = 8'd5;

  // Driven bus levels of one phase.
  typedef struct packed {
    logic sda;
    logic scl;
  } levels_t;

  // Number of phases in the sequence of each command.
  function automatic logic [4:0] phase_total(input cmd_e cmd);
    logic [4:0] total;
    unique case (cmd)
      CMD_START: total = 5'd3;
      CMD_STOP:  total = 5'd3;
      CMD_WRITE: total = 5'd25;
      CMD_READ:  total = 5'd18;
      CMD_SACK:  total = 5'd5;
      CMD_RACK:  total = 5'd4;
      default:   total = 5'd0;
    endcase
    return total;
  endfunction

  // Bit position of a write phase: phases after the first come in groups of three.
  function automatic logic [2:0] write_bit(input logic [4:0] q);
    logic [2:0] k;
    k = 3'(q >= 5'd3) + 3'(q >= 5'd6) + 3'(q >= 5'd9) + 3'(q >= 5'd12)
      + 3'(q >= 5'd15) + 3'(q >= 5'd18) + 3'(q >= 5'd21);
    return k;
  endfunction

  // Levels driven in phase p of a command.
  function automatic levels_t phase_levels(input cmd_e cmd, input logic [4:0] p,
                                           input levels_t last, input logic [7:0] shift,
                                           input logic ack);
    levels_t    lv;
    logic [4:0] q;
    logic [2:0] k;
    logic [4:0] r;
    lv = last;
    q  = p - 5'd1;
    k  = write_bit(q);
    r  = q - {1'b0, k, 1'b0} - {2'b00, k};
    unique case (cmd)
      CMD_START: begin
        if (p == 5'd0) begin
          lv.sda = 1'b1;
        end else if (p == 5'd1) begin
          lv = '{sda: 1'b1, scl: 1'b1};
        end else begin
          lv = '{sda: 1'b0, scl: 1'b1};
        end
      end
      CMD_STOP: begin
        if (p == 5'd0) begin
          lv.sda = 1'b0;
        end else if (p == 5'd1) begin
          lv = '{sda: 1'b0, scl: 1'b1};
        end else begin
          lv = '{sda: 1'b1, scl: 1'b1};
        end
      end
      CMD_WRITE: begin
        if (p == 5'd0) begin
          lv.scl = 1'b0;
        end else begin
          lv.sda = shift[3'd7 - k];
          lv.scl = (r == 5'd1);
        end
      end
      CMD_READ: begin
        if (p == 5'd0) begin
          lv.scl = 1'b0;
        end else if (p >= 5'd17) begin
          lv = '{sda: 1'b1, scl: 1'b0};
        end else begin
          lv = '{sda: 1'b1, scl: ~p[0]};
        end
      end
      CMD_SACK: begin
        if (p == 5'd0) begin
          lv.scl = 1'b0;
        end else if (p >= 5'd4) begin
          lv = '{sda: 1'b1, scl: 1'b0};
        end else begin
          lv = '{sda: ack, scl: (p == 5'd2)};
        end
      end
      CMD_RACK: begin
        if (p == 5'd0) begin
          lv.scl = 1'b0;
        end else begin
          lv = '{sda: 1'b1, scl: (p == 5'd2)};
        end
      end
      default: lv = last;
    endcase
    return lv;
  endfunction

  // Phases that end with an SDA sample.
  function automatic logic sample_phase(input cmd_e cmd, input logic [4:0] p);
    logic s;
    unique case (cmd)
      CMD_READ: s = (p >= 5'd2) && (p <= 5'd16) && !p[0];
      CMD_RACK: s = (p == 5'd2);
      default:  s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer: command handling, phase stepping, result register.
`default_nettype none

// Single-master I2C bit engine. Each input transfer is either a tick (operation 0, one
// time step of the bus) or a command (start, stop, write byte, read byte, send ACK, read
// ACK). A command is taken only while idle; it drives its first bus phase at once, and
// each later phase follows after half_period ticks (0 acts as 1). SDA is sampled from
// sda_in_i on the tick that ends each SCL-high phase of a read. Every input transfer
// yields exactly one result transfer with the driven levels, busy, done, read data, the
// received ACK level and the rejected flag. One input transfer is taken per clock; the
// result is registered in the output register, and the input stalls only while that
// register holds a result that the output side is stalling. The user must write half_period
// through cfg_we_i / cfg_wdata_i only while no command is in progress; the block does not check.
module i2c_master_bit_sequencer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [7:0]           cfg_wdata_i,
  // Input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [2:0]           operation_i,
  input  wire logic [7:0]           data_i,
  input  wire logic                 ack_level_i,
  input  wire logic                 sda_in_i,
  // Output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      sda_out_o,
  output logic                      scl_out_o,
  output logic                      busy_res_o,
  output logic                      done_res_o,
  output logic [7:0]                read_data_o,
  output logic                      ack_received_o,
  output logic                      rejected_o
);
  import i2cbs_pkg::*;

  logic [7:0]       half_q;
  i2cbs_pkg::levels_t lv_q, lv_d;
  cmd_e             cmd_q, cmd_d;
  logic [4:0]       phase_q, phase_d;
  logic [7:0]       tick_q, tick_d;
  logic [7:0]       shift_q, shift_d;
  logic             ack_q, ack_d;

  logic             out_valid_q;
  logic             sda_q, scl_q, busy_q, done_q, rack_q, rej_q;
  logic [7:0]       rdata_q;

  logic             in_fire;
  logic             done_d, rack_d, rej_d;
  logic [7:0]       rdata_d;
  logic [7:0]       hp;
  logic [7:0]       tick_inc;
  logic [7:0]       shift_smp;
  logic [4:0]       phase_inc;
  cmd_e             op;

  // Input is held back only while a finished result waits on a stalled output.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign op        = cmd_e'(operation_i);
  assign hp        = (half_q == 8'd0) ? 8'd1 : half_q;
  assign tick_inc  = tick_q + 8'd1;
  assign phase_inc = phase_q + 5'd1;
  assign shift_smp = sample_phase(cmd_q, phase_q) ? {shift_q[6:0], sda_in_i} : shift_q;

  // Command acceptance and phase stepping for one transfer.
  always_comb begin
    lv_d    = lv_q;
    cmd_d   = cmd_q;
    phase_d = phase_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    ack_d   = ack_q;
    done_d  = 1'b0;
    rdata_d = 8'd0;
    rack_d  = 1'b0;
    rej_d   = 1'b0;
    unique case (op)
      CMD_IDLE: begin
        if (cmd_q != CMD_IDLE) begin
          if (tick_inc >= hp) begin
            tick_d  = 8'd0;
            shift_d = shift_smp;
            if (phase_inc >= phase_total(cmd_q)) begin
              done_d  = 1'b1;
              rdata_d = (cmd_q == CMD_READ) ? shift_smp : 8'd0;
              rack_d  = (cmd_q == CMD_RACK) ? shift_smp[0] : 1'b0;
              cmd_d   = CMD_IDLE;
              phase_d = 5'd0;
            end else begin
              phase_d = phase_inc;
              lv_d    = phase_levels(cmd_q, phase_inc, lv_q, shift_smp, ack_q);
            end
          end else begin
            tick_d = tick_inc;
          end
        end
      end
      CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_SACK, CMD_RACK: begin
        if (cmd_q != CMD_IDLE) begin
          rej_d = 1'b1;
        end else begin
          cmd_d   = op;
          phase_d = 5'd0;
          tick_d  = 8'd0;
          shift_d = (op == CMD_WRITE) ? data_i : 8'd0;
          if (op == CMD_SACK) begin
            ack_d = ack_level_i;
          end
          lv_d = phase_levels(op, 5'd0, lv_q, shift_d, ack_d);
        end
      end
      default: begin
        // Unused operation code: nothing changes.
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfPeriodReset;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  // Sequencer state, updated on each accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q    <= '{sda: 1'b1, scl: 1'b1};
      cmd_q   <= CMD_IDLE;
      phase_q <= 5'd0;
      tick_q  <= 8'd0;
      shift_q <= 8'd0;
      ack_q   <= 1'b0;
    end else if (in_fire) begin
      lv_q    <= lv_d;
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sda_q   <= lv_d.sda;
      scl_q   <= lv_d.scl;
      busy_q  <= (cmd_d != CMD_IDLE);
      done_q  <= done_d;
      rdata_q <= rdata_d;
      rack_q  <= rack_d;
      rej_q   <= rej_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sda_out_o      = sda_q;
  assign scl_out_o      = scl_q;
  assign busy_res_o     = busy_q;
  assign done_res_o     = done_q;
  assign read_data_o    = rdata_q;
  assign ack_received_o = rack_q;
  assign rejected_o     = rej_q;

  // A finished command always leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !busy_q)
    else $error("done reported while still busy");

  // A command is only rejected while another one is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rej_q |-> busy_q)
    else $error("rejected reported while idle");

  // An idle sequencer holds cleared phase and tick counters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == CMD_IDLE |-> phase_q == 5'd0 && tick_q == 8'd0)
    else $error("counters not cleared while idle");

  // Phase index stays below the length of the active sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q != CMD_IDLE |-> phase_q < phase_total(cmd_q))
    else $error("phase index beyond end of sequence");

endmodule

`default_nettype wire

// ===== test/i2c_master_bit_sequencer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the I2C master bit sequencer: a directed table, then random commands and ticks.
module i2c_master_bit_sequencer_tb;
  import i2cbs_pkg::*;

  // Operation codes that are not commands.
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_NONE = 3'd7;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 110;

  // One result transfer as seen on the output channel.
  typedef struct packed {
    logic       sda;
    logic       scl;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       rack;
    logic       rej;
  } bus_result_t;

  // One row of the directed table; reps repeats the same input transfer.
  typedef struct {
    logic [2:0]  op;
    logic [7:0]  data;
    logic        ack;
    logic        sda;
    int          reps;
    bit          typed;
    bus_result_t want;
  } dir_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic [2:0] operation_i = OP_TICK;
  logic [7:0] data_i      = 8'h00;
  logic       ack_level_i = 1'b0;
  logic       sda_in_i    = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       sda_out_o;
  logic       scl_out_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] read_data_o;
  logic       ack_received_o;
  logic       rejected_o;

  // Predicted bus state and register copy.
  logic [7:0] half_period_cfg = HalfPeriodReset;
  logic       bus_sda         = 1'b1;
  logic       bus_scl         = 1'b1;
  cmd_e       cur_cmd         = CMD_IDLE;
  logic [4:0] cur_phase       = 5'd0;
  logic [7:0] tick_cnt        = 8'd0;
  logic [7:0] shift_reg       = 8'd0;
  logic       ack_held        = 1'b0;

  bus_result_t expected_bus_q[$];
  dir_row_t    dir_rows[$];
  int          hp_plan[7];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          stall_left     = 0;
  bit          quiet_in       = 1'b0;
  bit          quiet_out      = 1'b0;

  i2c_master_bit_sequencer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .data_i         (data_i),
    .ack_level_i    (ack_level_i),
    .sda_in_i       (sda_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sda_out_o      (sda_out_o),
    .scl_out_o      (scl_out_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .read_data_o    (read_data_o),
    .ack_received_o (ack_received_o),
    .rejected_o     (rejected_o)
  );

  always #1 clk_i = ~clk_i;

  // Cycle counter with a hard limit on the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_bus_q.size());
      $display("** i2c_master_bit_sequencer: FAILED **");
      $finish;
    end
  end

  // Idle length: mostly short, sometimes long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bus_result_t res(logic sda, logic scl, logic busy, logic done,
                                      logic [7:0] rdata, logic rack, logic rej);
    bus_result_t r;
    r = '{sda: sda, scl: scl, busy: busy, done: done, rdata: rdata, rack: rack, rej: rej};
    return r;
  endfunction

  // Number of bus phases in each command.
  function automatic logic [4:0] phase_count(cmd_e c);
    case (c)
      CMD_START: return 5'd3;
      CMD_STOP:  return 5'd3;
      CMD_WRITE: return 5'd25;
      CMD_READ:  return 5'd18;
      CMD_SACK:  return 5'd5;
      CMD_RACK:  return 5'd4;
      default:   return 5'd0;
    endcase
  endfunction

  // Set the predicted line levels for the current phase of the current command.
  function automatic void drive_phase();
    logic [4:0] q;
    logic [2:0] bitpos;
    q      = cur_phase - 5'd1;
    bitpos = 3'(q / 5'd3);
    case (cur_cmd)
      CMD_START: begin
        if (cur_phase == 5'd0) begin
          bus_sda = 1'b1;
        end else begin
          bus_sda = (cur_phase == 5'd1);
          bus_scl = 1'b1;
        end
      end
      CMD_STOP: begin
        if (cur_phase == 5'd0) begin
          bus_sda = 1'b0;
        end else begin
          bus_sda = (cur_phase == 5'd2);
          bus_scl = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (cur_phase == 5'd0) begin
          bus_scl = 1'b0;
        end else begin
          bus_sda = shift_reg[3'd7 - bitpos];
          bus_scl = (q % 5'd3 == 5'd1);
        end
      end
      CMD_READ: begin
        if (cur_phase == 5'd0) begin
          bus_scl = 1'b0;
        end else begin
          bus_sda = 1'b1;
          bus_scl = (cur_phase <= 5'd16) && !cur_phase[0];
        end
      end
      CMD_SACK: begin
        if (cur_phase == 5'd0) begin
          bus_scl = 1'b0;
        end else if (cur_phase >= 5'd4) begin
          bus_sda = 1'b1;
          bus_scl = 1'b0;
        end else begin
          bus_sda = ack_held;
          bus_scl = (cur_phase == 5'd2);
        end
      end
      CMD_RACK: begin
        if (cur_phase == 5'd0) begin
          bus_scl = 1'b0;
        end else begin
          bus_sda = 1'b1;
          bus_scl = (cur_phase == 5'd2);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Advance the predicted sequencer by one input transfer and give its result.
  function automatic void step_sequencer(input logic [2:0] op, input logic [7:0] data,
                                         input logic ack, input logic sda,
                                         output bus_result_t r);
    logic [7:0] hp;
    logic       sample;
    r  = '0;
    hp = (half_period_cfg == 8'd0) ? 8'd1 : half_period_cfg;
    if (op >= CMD_START && op <= CMD_RACK) begin
      if (cur_cmd != CMD_IDLE) begin
        r.rej = 1'b1;
      end else begin
        cur_cmd   = cmd_e'(op);
        cur_phase = 5'd0;
        tick_cnt  = 8'd0;
        shift_reg = (op == CMD_WRITE) ? data : 8'd0;
        if (op == CMD_SACK) ack_held = ack;
        drive_phase();
      end
    end else if (op == OP_TICK && cur_cmd != CMD_IDLE) begin
      tick_cnt++;
      if (tick_cnt >= hp) begin
        tick_cnt = 8'd0;
        // SDA is taken at the end of each SCL-high phase of a read.
        sample = (cur_cmd == CMD_READ && cur_phase >= 5'd2 && cur_phase <= 5'd16
                  && !cur_phase[0]) || (cur_cmd == CMD_RACK && cur_phase == 5'd2);
        if (sample) shift_reg = {shift_reg[6:0], sda};
        cur_phase++;
        if (cur_phase >= phase_count(cur_cmd)) begin
          r.done = 1'b1;
          if (cur_cmd == CMD_READ) r.rdata = shift_reg;
          if (cur_cmd == CMD_RACK) r.rack = shift_reg[0];
          cur_cmd   = CMD_IDLE;
          cur_phase = 5'd0;
        end else begin
          drive_phase();
        end
      end
    end
    r.sda  = bus_sda;
    r.scl  = bus_scl;
    r.busy = (cur_cmd != CMD_IDLE);
  endfunction

  // Send one input transfer, then record what it should produce.
  task automatic put_item(input logic [2:0] op, input logic [7:0] data, input logic ack,
                          input logic sda, input bit use_want, input bus_result_t want);
    int          gap;
    bus_result_t pred;
    gap = (!quiet_in && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_i      <= data;
    ack_level_i <= ack;
    sda_in_i    <= sda;
    do @(posedge clk_i); while (in_stall_o);
    step_sequencer(op, data, ack, sda, pred);
    expected_bus_q.push_back(use_want ? want : pred);
  endtask

  // Mostly well-formed traffic: commands while idle, ticks while busy, some noise.
  task automatic random_item();
    logic [2:0] op;
    logic [7:0] d;
    int         r;
    r = $urandom_range(0, 99);
    if (cur_cmd != CMD_IDLE) begin
      op = (r < 88) ? OP_TICK :
           (r < 96) ? 3'($urandom_range(int'(CMD_START), int'(CMD_RACK))) : OP_NONE;
    end else begin
      op = (r < 60) ? 3'($urandom_range(int'(CMD_START), int'(CMD_RACK))) :
           (r < 80) ? OP_TICK : OP_NONE;
    end
    r = $urandom_range(0, 9);
    d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    put_item(op, d, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // Tick until the running command ends, then wait for every result to come back.
  task automatic settle_bus();
    while (cur_cmd != CMD_IDLE) begin
      put_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (expected_bus_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_half_period(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    half_period_cfg = value;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Output side: random stall, and every result transfer checked against the oldest one due.
  always @(posedge clk_i) begin
    bus_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bus_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          mismatch_count++;
        end else begin
          want = expected_bus_q.pop_front();
          check_field("sda_out", want.sda, sda_out_o);
          check_field("scl_out", want.scl, scl_out_o);
          check_field("busy_res", want.busy, busy_res_o);
          check_field("done_res", want.done, done_res_o);
          check_field("read_data", want.rdata, read_data_o);
          check_field("ack_received", want.rack, ack_received_o);
          check_field("rejected", want.rej, rejected_o);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet_out && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin
    // Directed rows, reset half period: idle behavior, a full start, then a read with rejected commands.
    dir_rows.push_back('{OP_TICK, 8'h00, 1'b0, 1'b0, 1, 1'b1, res(1, 1, 0, 0, 8'h00, 0, 0)});
    dir_rows.push_back('{OP_NONE, 8'hFF, 1'b1, 1'b1, 1, 1'b1, res(1, 1, 0, 0, 8'h00, 0, 0)});
    dir_rows.push_back('{CMD_START, 8'h00, 1'b0, 1'b0, 1, 1'b1, res(1, 1, 1, 0, 8'h00, 0, 0)});
    dir_rows.push_back('{CMD_WRITE, 8'hFF, 1'b1, 1'b1, 1, 1'b1, res(1, 1, 1, 0, 8'h00, 0, 1)});
    dir_rows.push_back('{OP_NONE, 8'h00, 1'b0, 1'b0, 1, 1'b1, res(1, 1, 1, 0, 8'h00, 0, 0)});
    dir_rows.push_back('{OP_TICK, 8'h00, 1'b0, 1'b1, 14, 1'b0, res(0, 0, 0, 0, 8'h00, 0, 0)});
    dir_rows.push_back('{OP_TICK, 8'hFF, 1'b1, 1'b0, 1, 1'b1, res(0, 1, 0, 1, 8'h00, 0, 0)});
    dir_rows.push_back('{CMD_READ, 8'h00, 1'b0, 1'b0, 1, 1'b1, res(0, 0, 1, 0, 8'h00, 0, 0)});
    dir_rows.push_back('{CMD_RACK, 8'h00, 1'b0, 1'b1, 1, 1'b1, res(0, 0, 1, 0, 8'h00, 0, 1)});
    dir_rows.push_back('{CMD_SACK, 8'hFF, 1'b1, 1'b0, 1, 1'b1, res(0, 0, 1, 0, 8'h00, 0, 1)});
    dir_rows.push_back('{CMD_STOP, 8'h00, 1'b0, 1'b0, 1, 1'b1, res(0, 0, 1, 0, 8'h00, 0, 1)});
    hp_plan = '{int'(HalfPeriodReset), 1, 0, 2, 255, 3, 7};
    hp_plan[6] = $urandom_range(4, 9);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      for (int n = 0; n < dir_rows[i].reps; n++) begin
        put_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].ack, dir_rows[i].sda,
                 dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases; the first keeps the reset half period, the longest runs a single start.
    for (int k = 0; k < 7; k++) begin
      if (k != 0) begin
        settle_bus();
        set_half_period(8'(hp_plan[k]));
      end
      if (hp_plan[k] == 255) begin
        put_item(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0, '0);
      end else begin
        for (int i = 0; i < PHASE_ITEMS; i++) begin
          if (i % 50 == 0) begin
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
          end
          random_item();
        end
      end
    end
    settle_bus();

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** i2c_master_bit_sequencer: PASSED **");
    end else begin
      $display("** i2c_master_bit_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
